// File: hdl/rict_pkg.sv
// shared constants, codes and types for the inode slot table
`default_nettype none
package rict_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int KEY_BITS   = 16;
    localparam int COUNT_BITS = 16;
    localparam int SLOT_BITS  = $clog2(SLOT_COUNT);

    // fixed port widths
    localparam int INODE_W = 16;
    localparam int SLOT_W  = 6;
    localparam int STAT_W  = 2;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_PUT_FREE  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_SATURATED = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic update;
    } t_dp_cmd;

endpackage
`default_nettype wire

// File: hdl/rict_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module rict_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: hdl/rict_ctrl.sv
// request sequencer: capture, lookup, count update
`default_nettype none
module rict_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    output rict_pkg::t_dp_cmd     o_cmd
);
    import rict_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy        = 1'b0;
                o_cmd.capture = start;
            end
            ST_LOOKUP: o_cmd.lookup = 1'b1;
            ST_UPDATE: o_cmd.update = 1'b1;
            default:   busy = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/rict_dp.sv
// slot key cells, in-use bits, lookup encoders, count ram and result registers
`default_nettype none
module rict_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire rict_pkg::t_dp_cmd               i_cmd,
    input  wire logic                            i_kind,
    input  wire logic [rict_pkg::INODE_W-1:0]    i_inode_number,
    input  wire logic [rict_pkg::SLOT_W-1:0]     i_slot_index,
    input  wire logic                            i_no_links,
    output logic                                 o_valid,
    output logic      [rict_pkg::SLOT_W-1:0]     o_slot_out,
    output logic                                 o_hit,
    output logic                                 o_load_needed,
    output logic                                 o_released,
    output logic                                 o_free_on_disk,
    output logic      [rict_pkg::STAT_W-1:0]     o_status
);
    import rict_pkg::*;

    // captured request
    logic                  r_kind;
    logic [KEY_BITS-1:0]   r_key;
    logic [SLOT_W-1:0]     r_slot_idx;
    logic                  r_no_links;

    // table state
    logic [KEY_BITS-1:0]   r_keys [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_used;

    // lookup results
    logic [SLOT_BITS-1:0]  r_sel;
    logic                  r_hit;
    logic                  r_full;
    logic                  r_put_free;

    logic [SLOT_BITS-1:0]  n_sel;
    logic                  n_hit;
    logic                  n_full;
    logic                  n_put_free;

    logic [SLOT_COUNT-1:0] match_vec;
    logic [SLOT_BITS-1:0]  hit_idx;
    logic [SLOT_BITS-1:0]  free_idx;
    logic                  any_hit;
    logic                  any_free;

    logic                  cnt_we;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic [COUNT_BITS-1:0] cnt_rdata;

    logic                  r_valid;
    logic [SLOT_W-1:0]     r_slot_out;
    logic                  r_res_hit;
    logic                  r_res_load;
    logic                  r_res_rel;
    logic                  r_res_dfree;
    logic [STAT_W-1:0]     r_status;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind     <= i_kind;
            r_key      <= i_inode_number[KEY_BITS-1:0];
            r_slot_idx <= i_slot_index;
            r_no_links <= i_no_links;
        end
    end

    // parallel key compare over in-use slots
    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            match_vec[i] = r_used[i] && (r_keys[i] == r_key);
        end
    end

    // lowest matching slot and lowest free slot
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        any_hit  = 1'b0;
        any_free = 1'b0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (match_vec[i]) begin
                hit_idx = SLOT_BITS'(i);
                any_hit = 1'b1;
            end
            if (!r_used[i]) begin
                free_idx = SLOT_BITS'(i);
                any_free = 1'b1;
            end
        end
    end

    always_comb begin
        n_sel      = r_sel;
        n_hit      = 1'b0;
        n_full     = 1'b0;
        n_put_free = 1'b0;
        if (r_kind == KIND_PUT) begin
            n_sel      = r_slot_idx[SLOT_BITS-1:0];
            n_put_free = (32'(r_slot_idx) >= SLOT_COUNT) ||
                         !r_used[r_slot_idx[SLOT_BITS-1:0]];
        end else if (any_hit) begin
            n_sel = hit_idx;
            n_hit = 1'b1;
        end else if (any_free) begin
            n_sel = free_idx;
        end else begin
            n_sel  = '0;
            n_full = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_sel      <= n_sel;
            r_hit      <= n_hit;
            r_full     <= n_full;
            r_put_free <= n_put_free;
        end
    end

    rict_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (r_sel),
        .i_wdata (cnt_wdata),
        .i_raddr (n_sel),
        .o_rdata (cnt_rdata)
    );

    // count update and result for the beat
    always_comb begin
        cnt_we    = 1'b0;
        cnt_wdata = '0;
        if (i_cmd.update) begin
            if (r_kind == KIND_GET) begin
                if (r_hit) begin
                    cnt_we    = (cnt_rdata != {COUNT_BITS{1'b1}});
                    cnt_wdata = cnt_rdata + COUNT_BITS'(1);
                end else if (!r_full) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = COUNT_BITS'(1);
                end
            end else if (!r_put_free) begin
                cnt_we    = 1'b1;
                cnt_wdata = cnt_rdata - COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && r_kind == KIND_GET && !r_hit && !r_full) begin
            r_keys[r_sel] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.update;
            if (i_cmd.update) begin
                if (r_kind == KIND_GET && !r_hit && !r_full) begin
                    r_used[r_sel] <= 1'b1;
                end else if (r_kind == KIND_PUT && !r_put_free &&
                             cnt_rdata == COUNT_BITS'(1)) begin
                    r_used[r_sel] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_slot_out  <= SLOT_W'(r_sel);
            r_res_hit   <= 1'b0;
            r_res_load  <= 1'b0;
            r_res_rel   <= 1'b0;
            r_res_dfree <= 1'b0;
            r_status    <= STAT_OK;
            if (r_kind == KIND_GET) begin
                if (r_hit) begin
                    r_res_hit <= 1'b1;
                    if (cnt_rdata == {COUNT_BITS{1'b1}}) begin
                        r_status <= STAT_SATURATED;
                    end
                end else if (r_full) begin
                    r_slot_out <= '0;
                    r_status   <= STAT_FULL;
                end else begin
                    r_res_load <= 1'b1;
                end
            end else begin
                r_slot_out <= r_slot_idx;
                if (r_put_free) begin
                    r_status <= STAT_PUT_FREE;
                end else if (cnt_rdata == COUNT_BITS'(1)) begin
                    r_res_rel   <= 1'b1;
                    r_res_dfree <= r_no_links;
                end
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_slot_out     = r_slot_out;
    assign o_hit          = r_res_hit;
    assign o_load_needed  = r_res_load;
    assign o_released     = r_res_rel;
    assign o_free_on_disk = r_res_dfree;
    assign o_status       = r_status;

    a_claim_marks_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_load_needed |-> r_used[o_slot_out[SLOT_BITS-1:0]])
        else $error("claimed slot not marked in use");

    a_release_clears_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_released |-> !r_used[o_slot_out[SLOT_BITS-1:0]])
        else $error("released slot still marked in use");

    a_full_means_all_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STAT_FULL |-> &r_used)
        else $error("table full reported with a free slot");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && o_load_needed) && (!o_free_on_disk || o_released))
        else $error("inconsistent result flags");

    a_strobe_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |=> o_valid)
        else $error("update without result strobe");

endmodule
`default_nettype wire

// File: hdl/refcounted_inode_cache_table_core.sv
// top level of the reference-counted inode slot table
//
// Usage:
// - A request beat is taken at a rising edge where start is high and busy is
//   low. i_kind selects get (look up i_inode_number) or put (release
//   i_slot_index, with i_no_links telling whether the disk inode goes too).
// - Each request gives exactly one result beat: o_valid is high for one cycle
//   with o_slot_out, o_hit, o_load_needed, o_released, o_free_on_disk and
//   o_status. The receiver cannot stall; the result must be taken that cycle.
// - After capture, a request passes the lookup state and then the update
//   state, which registers the result. busy is high in both, so a new request
//   is taken only after both, even in the cycle its predecessor's result shows.
// - The steps are a lookup (parallel key compare over all slots plus
//   lowest-match and lowest-free encoders, which also addresses the count
//   ram read) and an update that takes the registered count and writes
//   the new value back through the ram's write port.
// - Reset (i_rst_n low, synchronous) frees every slot at once through the
//   per-slot in-use bits; no clearing pass is needed, busy is low after reset.
`default_nettype none
module refcounted_inode_cache_table_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         i_kind,
    input  wire logic [rict_pkg::INODE_W-1:0] i_inode_number,
    input  wire logic [rict_pkg::SLOT_W-1:0]  i_slot_index,
    input  wire logic                         i_no_links,
    output logic                              o_valid,
    output logic      [rict_pkg::SLOT_W-1:0]  o_slot_out,
    output logic                              o_hit,
    output logic                              o_load_needed,
    output logic                              o_released,
    output logic                              o_free_on_disk,
    output logic      [rict_pkg::STAT_W-1:0]  o_status
);
    import rict_pkg::*;

    t_dp_cmd dp_cmd;

    rict_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (dp_cmd)
    );

    rict_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_kind         (i_kind),
        .i_inode_number (i_inode_number),
        .i_slot_index   (i_slot_index),
        .i_no_links     (i_no_links),
        .o_valid        (o_valid),
        .o_slot_out     (o_slot_out),
        .o_hit          (o_hit),
        .o_load_needed  (o_load_needed),
        .o_released     (o_released),
        .o_free_on_disk (o_free_on_disk),
        .o_status       (o_status)
    );

endmodule
`default_nettype wire
